/* hdl/psmd_pkg.sv */
// Package for the PS/2 mouse packet decoder.
// Field widths, register indexes, event kinds and reset values.
// No dependencies.
package psmd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned PosW   = 16;
    localparam int unsigned ValW   = 10;
    localparam int unsigned BtnW   = 3;
    localparam int unsigned KindW  = 2;
    localparam int unsigned BidxW  = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW   = 16;

    localparam logic [PosW-1:0] MaxXReset = 16'd639;
    localparam logic [PosW-1:0] MaxYReset = 16'd399;
    localparam logic [PosW-1:0] PosXReset = 16'd320;
    localparam logic [PosW-1:0] PosYReset = 16'd200;

    typedef enum logic [KindW-1:0] {
        EVT_POS    = 2'd0,
        EVT_REL_X  = 2'd1,
        EVT_REL_Y  = 2'd2,
        EVT_BUTTON = 2'd3
    } t_event_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_X = 2'd0,
        CFG_MAX_Y = 2'd1,
        CFG_GRAB  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BYTE_FLAGS = 2'd0,
        BYTE_DX    = 2'd1,
        BYTE_DY    = 2'd2
    } t_byte_index;

endpackage

/* hdl/psmd_in_if.sv */
// Input word channel of the PS/2 mouse packet decoder: one mouse byte.
// Depends on psmd_pkg.
interface psmd_in_if;
    logic                         valid;
    logic                         ready;
    logic [psmd_pkg::ByteW-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* hdl/psmd_out_if.sv */
// Result word channel of the PS/2 mouse packet decoder: one event.
// Depends on psmd_pkg.
interface psmd_out_if;
    logic                               valid;
    logic                               ready;
    logic [psmd_pkg::KindW-1:0]         event_kind;
    logic [psmd_pkg::BidxW-1:0]         button_index;
    logic signed [psmd_pkg::ValW-1:0]   event_value;
    logic [psmd_pkg::PosW-1:0]          pos_x;
    logic [psmd_pkg::PosW-1:0]          pos_y;
    logic [psmd_pkg::BtnW-1:0]          buttons;
    logic                               last;

    modport source (output valid, output event_kind, output button_index,
                    output event_value, output pos_x, output pos_y,
                    output buttons, output last, input ready);
    modport sink   (input valid, input event_kind, input button_index,
                    input event_value, input pos_x, input pos_y,
                    input buttons, input last, output ready);
endinterface

/* hdl/ps2_mouse_packet_decoder.sv */
// Top level of the PS/2 mouse packet decoder.
// Depends on psmd_pkg, psmd_in_if and psmd_out_if.
//
// Usage:
//   i_byte takes one mouse byte per word. Three bytes form a packet; a
//   first byte without bit 3 is dropped. A complete packet without an
//   overflow bit gives one position word (absolute mode) or up to five
//   event words (grab mode: relative x, negated relative y, button
//   changes). The final word caused by a byte carries last.
//   Config: i_cfg_we with i_cfg_idx 0 max_x, 1 max_y, 2 grab_mode; write
//   only while the block is idle.
// Timing:
//   A byte is registered, decoded into a pending event set, and the events
//   leave through the output register one per cycle while the output is
//   not stalled. After the final byte of a packet is accepted, its first
//   result word passes the pending event set and then the output register.
//   Bytes are taken one per cycle while no events are pending; a packet
//   with events holds the decode stage until its last event is emitted.
// Reset: position 320/200, buttons 0, packet sync cleared, config defaults.
// Stall: a stalled output holds its word; pending events and then the
//   input register fill, and i_byte.ready drops.
module ps2_mouse_packet_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    psmd_in_if.sink                       i_byte,
    psmd_out_if.source                    o_evt,
    input  logic                          i_cfg_we,
    input  logic [psmd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [psmd_pkg::CfgW-1:0]     i_cfg_data
);

    localparam int unsigned PW = psmd_pkg::PosW;
    localparam int unsigned VW = psmd_pkg::ValW;

    // config
    logic [PW-1:0] r_max_x, r_max_y;
    logic          r_grab;

    // input register
    logic                        r_a_valid;
    logic [psmd_pkg::ByteW-1:0]  r_a_byte;

    // packet state
    logic [1:0]                  r_byte_idx, n_byte_idx;
    logic [psmd_pkg::ByteW-1:0]  r_pkt0, r_pkt1;
    logic [PW-1:0]               r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [psmd_pkg::BtnW-1:0]   r_btn, n_btn;

    // pending events: 0 pos, 1 rel x, 2 rel y, 3..5 buttons
    logic [5:0]                  r_pend, n_pend;
    logic signed [VW-1:0]        r_dx, r_ndy, n_dx, n_ndy;

    // output register
    logic                               r_o_valid;
    logic [psmd_pkg::KindW-1:0]         r_o_kind;
    logic [psmd_pkg::BidxW-1:0]         r_o_bidx;
    logic signed [VW-1:0]               r_o_val;
    logic [PW-1:0]                      r_o_px, r_o_py;
    logic [psmd_pkg::BtnW-1:0]          r_o_btn;
    logic                               r_o_last;

    logic out_free, emit, b_free, a_move;
    logic [5:0] low_bit, rest;
    logic [psmd_pkg::KindW-1:0]  e_kind;
    logic [psmd_pkg::BidxW-1:0]  e_bidx;
    logic signed [VW-1:0]        e_val;

    logic               is_final;
    logic [7:0]         flags;
    logic signed [VW-1:0] dx, dy;
    logic signed [PW+1:0] sum_x, sum_y;
    logic [psmd_pkg::BtnW-1:0] chg;

    assign out_free = !r_o_valid || o_evt.ready;
    assign emit     = out_free && (r_pend != 6'd0);
    assign low_bit  = r_pend & (~r_pend + 6'd1);
    assign rest     = r_pend & ~low_bit;
    assign b_free   = (r_pend == 6'd0) || (emit && rest == 6'd0);
    assign a_move   = r_a_valid && b_free;
    assign i_byte.ready = !r_a_valid || a_move;

    always_comb begin
        e_kind = psmd_pkg::EVT_POS;
        e_bidx = '0;
        e_val  = '0;
        if (low_bit[1]) begin
            e_kind = psmd_pkg::EVT_REL_X;
            e_val  = r_dx;
        end else if (low_bit[2]) begin
            e_kind = psmd_pkg::EVT_REL_Y;
            e_val  = r_ndy;
        end else if (low_bit[3]) begin
            e_kind = psmd_pkg::EVT_BUTTON;
            e_bidx = 2'd0;
            e_val  = {{(VW-1){1'b0}}, r_btn[0]};
        end else if (low_bit[4]) begin
            e_kind = psmd_pkg::EVT_BUTTON;
            e_bidx = 2'd1;
            e_val  = {{(VW-1){1'b0}}, r_btn[1]};
        end else if (low_bit[5]) begin
            e_kind = psmd_pkg::EVT_BUTTON;
            e_bidx = 2'd2;
            e_val  = {{(VW-1){1'b0}}, r_btn[2]};
        end
    end

    // decode of the registered byte
    assign is_final = (r_byte_idx != psmd_pkg::BYTE_FLAGS) &&
                      (r_byte_idx != psmd_pkg::BYTE_DX);
    assign flags = r_pkt0;
    assign dx    = {{(VW-8){flags[4]}}, r_pkt1};
    assign dy    = {{(VW-8){flags[5]}}, r_a_byte};
    assign sum_x = $signed({2'b00, r_pos_x}) + {{(PW+2-VW){dx[VW-1]}}, dx};
    assign sum_y = $signed({2'b00, r_pos_y}) - {{(PW+2-VW){dy[VW-1]}}, dy};
    assign chg   = flags[2:0] ^ r_btn;

    always_comb begin
        n_byte_idx = r_byte_idx;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_btn      = r_btn;
        n_pend     = 6'd0;
        n_dx       = dx;
        n_ndy      = -dy;
        if (r_byte_idx == psmd_pkg::BYTE_FLAGS) begin
            if (r_a_byte[3]) begin
                n_byte_idx = psmd_pkg::BYTE_DX;
            end
        end else if (r_byte_idx == psmd_pkg::BYTE_DX) begin
            n_byte_idx = psmd_pkg::BYTE_DY;
        end else begin
            n_byte_idx = psmd_pkg::BYTE_FLAGS;
            if (flags[7:6] == 2'b00) begin
                n_btn = flags[2:0];
                if (r_grab) begin
                    n_pend = {chg, (dy != '0), (dx != '0), 1'b0};
                end else begin
                    n_pend = 6'd1;
                    if (sum_x[PW+1]) begin
                        n_pos_x = '0;
                    end else if (sum_x > $signed({2'b00, r_max_x})) begin
                        n_pos_x = r_max_x;
                    end else begin
                        n_pos_x = sum_x[PW-1:0];
                    end
                    if (sum_y[PW+1]) begin
                        n_pos_y = '0;
                    end else if (sum_y > $signed({2'b00, r_max_y})) begin
                        n_pos_y = r_max_y;
                    end else begin
                        n_pos_y = sum_y[PW-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x    <= psmd_pkg::MaxXReset;
            r_max_y    <= psmd_pkg::MaxYReset;
            r_grab     <= 1'b0;
            r_a_valid  <= 1'b0;
            r_byte_idx <= psmd_pkg::BYTE_FLAGS;
            r_pos_x    <= psmd_pkg::PosXReset;
            r_pos_y    <= psmd_pkg::PosYReset;
            r_btn      <= '0;
            r_pend     <= 6'd0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    psmd_pkg::CFG_MAX_X: r_max_x <= i_cfg_data[PW-1:0];
                    psmd_pkg::CFG_MAX_Y: r_max_y <= i_cfg_data[PW-1:0];
                    psmd_pkg::CFG_GRAB:  r_grab  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_byte.ready) begin
                r_a_valid <= i_byte.valid;
            end
            if (emit) begin
                r_pend <= rest;
            end
            if (a_move) begin
                r_byte_idx <= n_byte_idx;
                r_pos_x    <= n_pos_x;
                r_pos_y    <= n_pos_y;
                r_btn      <= n_btn;
                r_pend     <= n_pend;
            end
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_a_byte <= i_byte.data_byte;
        end
        if (a_move) begin
            if (r_byte_idx == psmd_pkg::BYTE_FLAGS) begin
                r_pkt0 <= r_a_byte;
            end else if (!is_final) begin
                r_pkt1 <= r_a_byte;
            end
            r_dx  <= n_dx;
            r_ndy <= n_ndy;
        end
        if (emit) begin
            r_o_kind <= e_kind;
            r_o_bidx <= e_bidx;
            r_o_val  <= e_val;
            r_o_px   <= r_pos_x;
            r_o_py   <= r_pos_y;
            r_o_btn  <= r_btn;
            r_o_last <= (rest == 6'd0);
        end
    end

    assign o_evt.valid        = r_o_valid;
    assign o_evt.event_kind   = r_o_kind;
    assign o_evt.button_index = r_o_bidx;
    assign o_evt.event_value  = r_o_val;
    assign o_evt.pos_x        = r_o_px;
    assign o_evt.pos_y        = r_o_py;
    assign o_evt.buttons      = r_o_btn;
    assign o_evt.last         = r_o_last;

endmodule
